@@ sv/bls_pkg.sv @@
// ----------------------------------------------------------------------------
// bls_pkg
// Shared constants, codes and controller/datapath interface types for the
// bounded LIFO stack.
// ----------------------------------------------------------------------------
package bls_pkg;

  localparam int DEPTH   = 64;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW      = $clog2(DEPTH + 1);
  localparam int WORD_W  = 32;
  localparam int CAP_W   = 7;
  localparam int LVL_W   = 7;
  localparam int CMP_W   = (CW > CAP_W) ? CW : CAP_W;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

  typedef enum logic [1:0] {
    FN_PUSH      = 2'd0,
    FN_POP       = 2'd1,
    FN_DUMP_DOWN = 2'd2,
    FN_DUMP_UP   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_SEND
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic start;  // input transaction taken this cycle
    logic step;   // dump result taken, fetch the next word
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last;   // current result is the final one of this item
  } sts_t;

endpackage

@@ sv/bls_ram.sv @@
// ----------------------------------------------------------------------------
// bls_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/bls_ctrl.sv @@
// ----------------------------------------------------------------------------
// bls_ctrl
// Handshake controller: takes one item, then holds the result channel until
// the final result of that item has been taken.
// ----------------------------------------------------------------------------
module bls_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output bls_pkg::cmd_t cmd_o,
  input  bls_pkg::sts_t sts_i
);
  import bls_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_SEND;
      end
      S_SEND: begin
        if (out_ready_i && sts_i.last) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      S_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.start = in_valid_i;
      end
      S_SEND: begin
        out_valid_o = 1'b1;
        cmd_o.step  = out_ready_i && !sts_i.last;
      end
      default: ;
    endcase
  end

endmodule

@@ sv/bls_dp.sv @@
// ----------------------------------------------------------------------------
// bls_dp
// Stack datapath: fill count, capacity register, dump pointer and counter,
// result registers and the entry RAM.
// ----------------------------------------------------------------------------
module bls_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bls_pkg::cmd_t                cmd_i,
  output bls_pkg::sts_t                sts_o,
  input  logic                         cfg_we_i,
  input  logic [bls_pkg::CAP_W-1:0]    cfg_capacity_i,
  input  logic [1:0]                   func_i,
  input  logic signed [bls_pkg::WORD_W-1:0] push_value_i,
  output logic signed [bls_pkg::WORD_W-1:0] word_out_o,
  output logic [1:0]                   status_o,
  output logic [bls_pkg::LVL_W-1:0]    fill_level_o,
  output logic                         last_o
);
  import bls_pkg::*;

  logic [CW-1:0]     held_q, held_d;
  logic [CAP_W-1:0]  cap_q;
  logic [CW-1:0]     rem_q, rem_d;
  logic [AW-1:0]     ptr_q, ptr_d;
  logic              up_q, up_d;
  logic              dump_q, dump_d;
  logic              src_ram_q, src_ram_d;
  status_e           status_q, status_d;
  logic [WORD_W-1:0] word_q, word_d;

  logic              is_empty, is_full;
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  assign is_empty = (held_q == '0);
  // limit in force is min(capacity, DEPTH); held never exceeds DEPTH
  assign is_full  = (CMP_W'(held_q) >= CMP_W'(cap_q)) || (held_q == CW'(DEPTH));

  always_comb begin
    held_d    = held_q;
    rem_d     = rem_q;
    ptr_d     = ptr_q;
    up_d      = up_q;
    dump_d    = dump_q;
    src_ram_d = src_ram_q;
    status_d  = status_q;
    word_d    = word_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = ptr_q;

    if (cmd_i.start) begin
      dump_d    = 1'b0;
      src_ram_d = 1'b0;
      status_d  = ST_OK;
      word_d    = '0;
      case (func_e'(func_i))
        FN_PUSH: begin
          if (is_full) begin
            status_d = ST_FULL;
          end else begin
            ram_we = 1'b1;
            held_d = held_q + 1'b1;
          end
        end
        FN_POP: begin
          if (is_empty) begin
            status_d = ST_EMPTY;
            word_d   = '1;
          end else begin
            held_d    = held_q - 1'b1;
            ram_re    = 1'b1;
            ram_raddr = AW'(held_q - 1'b1);
            src_ram_d = 1'b1;
          end
        end
        FN_DUMP_DOWN, FN_DUMP_UP: begin
          if (is_empty) begin
            status_d = ST_EMPTY;
            word_d   = '1;
          end else begin
            dump_d    = 1'b1;
            rem_d     = held_q;
            up_d      = (func_e'(func_i) == FN_DUMP_UP);
            ptr_d     = up_d ? '0 : AW'(held_q - 1'b1);
            ram_re    = 1'b1;
            ram_raddr = ptr_d;
            src_ram_d = 1'b1;
          end
        end
        default: ;
      endcase
    end else if (cmd_i.step) begin
      rem_d     = rem_q - 1'b1;
      ptr_d     = up_q ? ptr_q + 1'b1 : ptr_q - 1'b1;
      ram_re    = 1'b1;
      ram_raddr = ptr_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      cap_q  <= CAP_RESET;
      rem_q  <= '0;
      dump_q <= 1'b0;
    end else begin
      held_q <= held_d;
      rem_q  <= rem_d;
      dump_q <= dump_d;
      if (cfg_we_i) cap_q <= cfg_capacity_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q     <= ptr_d;
    up_q      <= up_d;
    src_ram_q <= src_ram_d;
    status_q  <= status_d;
    word_q    <= word_d;
  end

  bls_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(held_q)),
    .wdata_i (push_value_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign sts_o.last   = !dump_q || (rem_q == CW'(1));
  assign word_out_o   = src_ram_q ? ram_rdata : word_q;
  assign status_o     = status_q;
  assign fill_level_o = LVL_W'(held_q);
  assign last_o       = sts_o.last;

endmodule

@@ sv/bounded_lifo_stack.sv @@
// ----------------------------------------------------------------------------
// bounded_lifo_stack
// Bounded LIFO stack of signed 32-bit words with a programmable capacity.
// ----------------------------------------------------------------------------
// Channels: an input channel (func_i, push_value_i) and a result channel
// (word_out_o, status_o, fill_level_o, last_o), both valid/ready; a
// transaction completes when valid and ready are high at a clock edge.
// The capacity register is written over its own valid/ready channel
// (cfg_capacity_i), which is always ready; write it only while idle.
// One item is in flight at a time. A push, pop or empty-stack operation
// gives its single result in the cycle after acceptance and the next item is
// taken in the cycle after that result is taken.
// A dump gives one result per held word, one per cycle while the receiver
// is ready, the first in the cycle after acceptance; each result read is one
// access of the single-read-port entry RAM. last_o marks the final result.
// If the receiver stalls, the current result is held unchanged and no new
// item is taken. Reset empties the stack and sets the capacity to 64; the
// entry RAM is not cleared, as no word is read before it is pushed.
// ----------------------------------------------------------------------------
module bounded_lifo_stack (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [bls_pkg::CAP_W-1:0]         cfg_capacity_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        func_i,
  input  logic signed [bls_pkg::WORD_W-1:0] push_value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [bls_pkg::WORD_W-1:0] word_out_o,
  output logic [1:0]                        status_o,
  output logic [bls_pkg::LVL_W-1:0]         fill_level_o,
  output logic                              last_o
);
  import bls_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  bls_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  bls_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_capacity_i (cfg_capacity_i),
    .func_i         (func_i),
    .push_value_i   (push_value_i),
    .word_out_o     (word_out_o),
    .status_o       (status_o),
    .fill_level_o   (fill_level_o),
    .last_o         (last_o)
  );

  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while a result is pending");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> out_valid_o)
    else $error("no result after an accepted item");

  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_EMPTY) |->
      (fill_level_o == '0 && word_out_o == -32'sd1 && last_o))
    else $error("malformed empty-stack result");

  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_level_o <= LVL_W'(DEPTH))
    else $error("fill level beyond depth");

endmodule

@@ sim/stack_check_pkg.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stack_check_pkg
// Result prediction and checking for the bounded LIFO stack: keeps its own
// copy of the stack and the capacity, works out the results each accepted
// operation should give, and compares the results the block returns.
// ----------------------------------------------------------------------------
package stack_check_pkg;

  import bls_pkg::*;

  typedef struct {
    logic signed [WORD_W-1:0] word;
    status_e                  status;
    logic [LVL_W-1:0]         level;
    logic                     last;
  } stack_result_t;

  class stack_scoreboard;

    logic signed [WORD_W-1:0] entries [DEPTH];
    int unsigned              held;
    int unsigned              capacity;
    stack_result_t            expected_q [$];
    int unsigned              mismatches;
    int unsigned              items_seen;
    int unsigned              results_seen;
    int unsigned              full_drops;
    int unsigned              empty_hits;

    function new();
      held         = 0;
      capacity     = CAP_RESET;
      mismatches   = 0;
      items_seen   = 0;
      results_seen = 0;
      full_drops   = 0;
      empty_hits   = 0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] cap);
      capacity = cap;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void queue_result(logic signed [WORD_W-1:0] word, status_e st,
                               int unsigned level, bit last);
      stack_result_t r;
      r.word   = word;
      r.status = st;
      r.level  = LVL_W'(level);
      r.last   = last;
      expected_q.push_back(r);
    endfunction

    // called once per accepted input transaction
    function void note_item(func_e fn, logic signed [WORD_W-1:0] value);
      int unsigned limit;
      int unsigned idx;
      limit = (capacity > DEPTH) ? DEPTH : capacity;
      items_seen++;
      if (fn == FN_PUSH) begin
        if (held >= limit) begin
          queue_result(0, ST_FULL, held, 1'b1);
          full_drops++;
        end else begin
          entries[held] = value;
          held++;
          queue_result(0, ST_OK, held, 1'b1);
        end
      end else if (held == 0) begin
        queue_result(-1, ST_EMPTY, 0, 1'b1);
        empty_hits++;
      end else if (fn == FN_POP) begin
        held--;
        queue_result(entries[held], ST_OK, held, 1'b1);
      end else begin
        for (idx = 0; idx < held; idx++)
          queue_result(entries[(fn == FN_DUMP_DOWN) ? held - 1 - idx : idx], ST_OK, held,
                       idx + 1 == held);
      end
    endfunction

    task flag_mismatch(string what);
      $display("%0t ns  mismatch: %s", $time, what);
      mismatches++;
    endtask

    task check_result(logic signed [WORD_W-1:0] word, logic [1:0] status,
                      logic [LVL_W-1:0] level, logic last);
      stack_result_t want;
      if (expected_q.size() == 0) begin
        flag_mismatch($sformatf("result word %0d with nothing pending", word));
        return;
      end
      want = expected_q.pop_front();
      results_seen++;
      if (word !== want.word)
        flag_mismatch($sformatf("word_out %0d, want %0d", word, want.word));
      if (status !== want.status)
        flag_mismatch($sformatf("status %0d, want %s", status, want.status.name()));
      if (level !== want.level)
        flag_mismatch($sformatf("fill_level %0d, want %0d", level, want.level));
      if (last !== want.last)
        flag_mismatch($sformatf("last %0b, want %0b", last, want.last));
    endtask

  endclass

endpackage

@@ sim/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the bounded LIFO stack: directed corner operations, then
// random push/pop/dump runs under several capacities, with random idle and
// stall bursts on both channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;

  import bls_pkg::*;
  import stack_check_pkg::*;

  localparam int unsigned LONG_HOLD      = 300;
  localparam int unsigned WATCHDOG_LIMIT = 5000;

  logic                     clk_i          = 1'b0;
  logic                     rst_ni         = 1'b0;
  logic                     cfg_valid_i    = 1'b0;
  logic                     cfg_ready_o;
  logic [CAP_W-1:0]         cfg_capacity_i = CAP_RESET;
  logic                     in_valid_i     = 1'b0;
  logic                     in_ready_o;
  logic [1:0]               func_i         = FN_PUSH;
  logic signed [WORD_W-1:0] push_value_i   = '0;
  logic                     out_valid_o;
  logic                     out_ready_i    = 1'b0;
  logic signed [WORD_W-1:0] word_out_o;
  logic [1:0]               status_o;
  logic [LVL_W-1:0]         fill_level_o;
  logic                     last_o;

  stack_scoreboard board = new();

  bit          quiet        = 1'b0;
  bit          hold_request = 1'b0;
  bit          hold_served  = 1'b0;
  int unsigned stall_left   = 0;
  int unsigned idle_cycles  = 0;
  int unsigned cfg_writes   = 0;

  bounded_lifo_stack dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_capacity_i(cfg_capacity_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .func_i        (func_i),
    .push_value_i  (push_value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .word_out_o    (word_out_o),
    .status_o      (status_o),
    .fill_level_o  (fill_level_o),
    .last_o        (last_o)
  );

  always #6 clk_i = ~clk_i;

  // result side: check every result transaction, then pick next ready
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      board.check_result(word_out_o, status_o, fill_level_o, last_o);
    if (hold_request && !hold_served) begin
      stall_left  = LONG_HOLD;
      hold_served = 1'b1;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (rst_ni && !quiet && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 16);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= rst_ni;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", idle_cycles);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  function automatic logic signed [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return -1;
      3:       return 0;
      default: return $urandom;
    endcase
  endfunction

  // valid is left high after acceptance, so back-to-back items keep it high unless a random gap drops it
  task automatic send_item(input func_e fn, input logic signed [WORD_W-1:0] value);
    int unsigned gap;
    gap = (!quiet && $urandom_range(0, 4) == 0) ? $urandom_range(1, 17) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    func_i       <= fn;
    push_value_i <= value;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_item(fn, value);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    cfg_valid_i    <= 1'b1;
    cfg_capacity_i <= cap;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    board.set_capacity(cap);
    cfg_writes++;
  endtask

  // runs of filling or draining so the stack sweeps between empty and full
  task automatic run_random_phase(input int unsigned n_items, input int unsigned fill_first);
    int unsigned k;
    int unsigned run_left;
    int unsigned r;
    bit          filling;
    func_e       fn;
    filling  = 1'b1;
    run_left = fill_first;
    for (k = 0; k < n_items; k++) begin
      if (run_left == 0) begin
        filling  = ($urandom_range(0, 1) == 1);
        run_left = $urandom_range(8, 40);
      end
      run_left--;
      r = $urandom_range(0, 99);
      if (r < 5)
        fn = FN_DUMP_DOWN;
      else if (r < 10)
        fn = FN_DUMP_UP;
      else if (r < (filling ? 90 : 25))
        fn = FN_PUSH;
      else
        fn = FN_POP;
      send_item(fn, pick_word());
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty stack at reset capacity
    send_item(FN_POP, 0);
    send_item(FN_DUMP_DOWN, 0);
    send_item(FN_DUMP_UP, 0);
    send_item(FN_PUSH, 32'sh8000_0000);
    send_item(FN_PUSH, 32'sh7fff_ffff);
    send_item(FN_PUSH, -1);
    send_item(FN_PUSH, 0);
    send_item(FN_PUSH, 1);
    send_item(FN_DUMP_DOWN, 0);
    send_item(FN_DUMP_UP, 0);
    send_item(FN_POP, 0);
    send_item(FN_POP, 0);

    // capacity zero: every push dropped, held words still readable
    write_capacity(7'd0);
    send_item(FN_PUSH, 32'sh1234_5678);
    send_item(FN_DUMP_UP, 0);
    send_item(FN_POP, 0);

    // capacity lowered below the held count
    write_capacity(7'd1);
    send_item(FN_PUSH, 32'sh0bad_cafe);
    send_item(FN_POP, 0);
    send_item(FN_PUSH, 32'sh5555_aaaa);
    send_item(FN_POP, 0);
    send_item(FN_PUSH, 32'shaaaa_5555);
    send_item(FN_PUSH, 32'sh0000_0001);
    send_item(FN_DUMP_DOWN, 0);

    // capacity above the depth, limited to the depth
    write_capacity(7'd127);
    send_item(FN_PUSH, 32'shdead_beef);
    send_item(FN_DUMP_UP, 0);

    run_random_phase(120, 100);

    write_capacity(7'd64);
    hold_request = 1'b1;
    run_random_phase(60, 20);

    write_capacity(7'd1);
    run_random_phase(40, 10);

    write_capacity(7'd0);
    run_random_phase(30, 0);

    write_capacity(7'd3);
    run_random_phase(50, 10);

    write_capacity(CAP_W'($urandom_range(2, 63)));
    run_random_phase(60, 30);

    write_capacity(CAP_W'($urandom_range(0, 127)));
    run_random_phase(60, 30);

    write_capacity(7'd64);
    quiet = 1'b1;
    run_random_phase(50, 40);

    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("covered %0d operations and %0d results over %0d capacity writes",
             board.items_seen, board.results_seen, cfg_writes);
    $display("%0d pushes refused on a full stack, %0d pops or dumps on an empty one",
             board.full_drops, board.empty_hits);
    if (board.mismatches == 0 && board.pending() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ bounded_lifo_stack.f @@
sv/bls_pkg.sv
sv/bls_ram.sv
sv/bls_ctrl.sv
sv/bls_dp.sv
sv/bounded_lifo_stack.sv
sim/stack_check_pkg.sv
sim/tb.sv
